@@ rtl/lpm_pkg.sv @@
package lpm_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned PORT_W = 8;

  localparam logic [ADDR_W-1:0] MISS_PREFIX = 32'h0102_0304;
  localparam logic [LEN_W-1:0]  MAX_LEN     = 6'd32;

  typedef enum logic [0:0] {
    MODE_ADD    = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } scan_ctl_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
  } best_t;

  // Keep the top len bits of a word; len is 0 to 32.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

@@ rtl/lpm_mem.sv @@
module lpm_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_idx,
  input  lpm_pkg::entry_t    wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_idx,
  output lpm_pkg::entry_t    rd_data
);

  lpm_pkg::entry_t mem [DEPTH];
  lpm_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/lpm_best.sv @@
module lpm_best (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpm_pkg::scan_ctl_t          ctl,
  input  logic [lpm_pkg::ADDR_W-1:0]  addr,
  input  lpm_pkg::entry_t             entry,
  output lpm_pkg::best_t              best
);

  logic                        found_r;
  logic [lpm_pkg::ADDR_W-1:0]  prefix_r;
  logic [lpm_pkg::LEN_W-1:0]   len_r;
  logic [lpm_pkg::PORT_W-1:0]  port_r;
  logic                        match;
  logic                        take;

  assign match = ((addr ^ entry.prefix) & lpm_pkg::prefix_mask(entry.len)) == '0;
  // Strictly longer only, so the earliest of equal lengths stays.
  assign take  = ctl.vld && match && (!found_r || (entry.len > len_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctl.clear) begin
      prefix_r <= entry.prefix;
      len_r    <= entry.len;
      port_r   <= entry.port;
    end
  end

  assign best = '{found: found_r, prefix: prefix_r, len: len_r, port: port_r};

endmodule

@@ rtl/longest_prefix_match_table.sv @@
// IPv4 route table with longest-prefix match over up to TABLE_DEPTH routes.
// Input: an item is taken at a rising edge with start high and busy low.
// in_mode 0 appends a route (in_address, in_prefix_len saturated to 32,
// in_port); in_mode 1 looks up in_address.
// Output: every item gives one result, shown for one cycle with out_valid
// high; the receiver cannot stall it and the block never waits on it.
// An add, or a lookup on an empty table, shows its result in the cycle after
// acceptance and the next item may be taken one cycle after acceptance.
// A lookup streams the N stored routes out of a one-port-read table memory,
// one entry a cycle, and compares each against the address; the best match
// is registered, then the finish state loads the output registers, and busy
// drops together with out_valid, so no new item is taken before the result.
// Adds to a full table are dropped and flagged with out_add_rejected.
// On a miss the result is hit 0, prefix 0x01020304, length 0, port 0.
// Reset empties the table (route count to zero) and returns to idle.
module longest_prefix_match_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [31:0]                 in_address,
  input  logic [5:0]                  in_prefix_len,
  input  logic [7:0]                  in_port,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [31:0]                 out_matched_prefix,
  output logic [5:0]                  out_matched_len,
  output logic [7:0]                  out_out_port,
  output logic                        out_add_rejected
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  lpm_pkg::state_t             state_r, state_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic                        issuing_r, issuing_nxt;
  logic [31:0]                 addr_r, addr_nxt;
  logic                        rd_vld_r, rd_last_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        hit_r, hit_nxt;
  logic [31:0]                 prefix_r, prefix_nxt;
  logic [5:0]                  len_r, len_nxt;
  logic [7:0]                  port_r, port_nxt;
  logic                        rej_r, rej_nxt;

  logic                        full;
  logic [CNT_W-1:0]            last_cnt;
  logic                        rd_en;
  logic                        rd_last;
  logic                        wr_en;
  logic                        best_clear;
  lpm_pkg::entry_t             wr_data;
  lpm_pkg::entry_t             rd_data;
  lpm_pkg::scan_ctl_t          scan_ctl;
  lpm_pkg::best_t              best;

  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign last_cnt = count_r - CNT_W'(1);
  assign rd_en    = (state_r == lpm_pkg::ST_SCAN) && issuing_r;
  assign rd_last  = rd_en && (idx_r == last_cnt[IDX_W-1:0]);
  assign busy     = (state_r != lpm_pkg::ST_IDLE);

  assign wr_data.prefix = in_address;
  assign wr_data.len    = (in_prefix_len > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN : in_prefix_len;
  assign wr_data.port   = in_port;

  assign scan_ctl.clear = best_clear;
  assign scan_ctl.vld   = rd_vld_r;

  lpm_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (count_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (idx_r),
    .rd_data (rd_data)
  );

  lpm_best u_best (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .addr  (addr_r),
    .entry (rd_data),
    .best  (best)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    issuing_nxt   = issuing_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    hit_nxt       = hit_r;
    prefix_nxt    = prefix_r;
    len_nxt       = len_r;
    port_nxt      = port_r;
    rej_nxt       = rej_r;
    wr_en         = 1'b0;
    best_clear    = 1'b0;
    case (state_r)
      lpm_pkg::ST_IDLE: begin
        if (start) begin
          if (in_mode == lpm_pkg::MODE_ADD) begin
            out_valid_nxt = 1'b1;
            hit_nxt       = 1'b0;
            prefix_nxt    = '0;
            len_nxt       = '0;
            port_nxt      = '0;
            rej_nxt       = full;
            if (!full) begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            hit_nxt       = 1'b0;
            prefix_nxt    = lpm_pkg::MISS_PREFIX;
            len_nxt       = '0;
            port_nxt      = '0;
            rej_nxt       = 1'b0;
          end else begin
            addr_nxt    = in_address;
            idx_nxt     = '0;
            issuing_nxt = 1'b1;
            best_clear  = 1'b1;
            state_nxt   = lpm_pkg::ST_SCAN;
          end
        end
      end
      lpm_pkg::ST_SCAN: begin
        if (issuing_r) begin
          if (rd_last) begin
            issuing_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        // Advance once the last entry has been compared.
        if (rd_vld_r && rd_last_r) begin
          state_nxt = lpm_pkg::ST_FIN;
        end
      end
      lpm_pkg::ST_FIN: begin
        out_valid_nxt = 1'b1;
        hit_nxt       = best.found;
        prefix_nxt    = best.found ? best.prefix : lpm_pkg::MISS_PREFIX;
        len_nxt       = best.found ? best.len : '0;
        port_nxt      = best.found ? best.port : '0;
        rej_nxt       = 1'b0;
        state_nxt     = lpm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lpm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpm_pkg::ST_IDLE;
      count_r     <= '0;
      issuing_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issuing_r   <= issuing_nxt;
      rd_vld_r    <= rd_en;
      rd_last_r   <= rd_last;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    addr_r   <= addr_nxt;
    hit_r    <= hit_nxt;
    prefix_r <= prefix_nxt;
    len_r    <= len_nxt;
    port_r   <= port_nxt;
    rej_r    <= rej_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = hit_r;
  assign out_matched_prefix = prefix_r;
  assign out_matched_len    = len_r;
  assign out_out_port       = port_r;
  assign out_add_rejected   = rej_r;

endmodule

@@ tb/longest_prefix_match_table_test.sv @@
`timescale 1ns / 1ps

module longest_prefix_match_table_test;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct packed {
    logic                       hit;
    logic [lpm_pkg::ADDR_W-1:0] prefix;
    logic [lpm_pkg::LEN_W-1:0]  len;
    logic [lpm_pkg::PORT_W-1:0] port;
    logic                       rejected;
  } route_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [31:0]       in_address;
  logic [5:0]        in_prefix_len;
  logic [7:0]        in_port;
  logic              out_valid;
  logic              out_hit;
  logic [31:0]       out_matched_prefix;
  logic [5:0]        out_matched_len;
  logic [7:0]        out_out_port;
  logic              out_add_rejected;

  // Mirror of the route table, updated on each accepted add that finds room
  logic [lpm_pkg::ADDR_W-1:0] route_prefix [DEPTH];
  logic [lpm_pkg::LEN_W-1:0]  route_len [DEPTH];
  logic [lpm_pkg::PORT_W-1:0] route_port [DEPTH];
  int unsigned                route_count;

  route_result_t     pending_results [$];
  int unsigned       mismatches;
  bit                steady;
  int unsigned       quiet_left;

  longest_prefix_match_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_address         (in_address),
    .in_prefix_len      (in_prefix_len),
    .in_port            (in_port),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_matched_prefix (out_matched_prefix),
    .out_matched_len    (out_matched_len),
    .out_out_port       (out_out_port),
    .out_add_rejected   (out_add_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [lpm_pkg::ADDR_W-1:0] prefix_keep(
      input logic [lpm_pkg::LEN_W-1:0] len);
    return (len == '0) ? '0 : ~(32'hFFFF_FFFF >> len);
  endfunction

  function automatic route_result_t predict_route_result(
      input lpm_pkg::mode_t mode,
      input logic [lpm_pkg::ADDR_W-1:0] addr,
      input logic [lpm_pkg::LEN_W-1:0] plen,
      input logic [lpm_pkg::PORT_W-1:0] prt);
    route_result_t             r;
    logic                      found;
    int unsigned               best;
    logic [lpm_pkg::LEN_W-1:0] best_len;
    r = '0;
    found = 1'b0;
    best = 0;
    best_len = '0;
    if (mode == lpm_pkg::MODE_ADD) begin
      if (route_count >= DEPTH) begin
        r.rejected = 1'b1;
      end else begin
        route_prefix[route_count] = addr;
        route_len[route_count] = (plen > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN : plen;
        route_port[route_count] = prt;
        route_count++;
      end
    end else begin
      // Strictly longer only, so the earliest route keeps a tie
      for (int unsigned i = 0; i < route_count; i++) begin
        if ((!found || route_len[i] > best_len) &&
            ((addr ^ route_prefix[i]) & prefix_keep(route_len[i])) == '0) begin
          found = 1'b1;
          best = i;
          best_len = route_len[i];
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.prefix = route_prefix[best];
        r.len = route_len[best];
        r.port = route_port[best];
      end else begin
        r.prefix = lpm_pkg::MISS_PREFIX;
      end
    end
    return r;
  endfunction

  function automatic string show_result(input route_result_t r);
    return $sformatf("hit=%0b prefix=%h len=%0d port=%0d rejected=%0b",
                     r.hit, r.prefix, r.len, r.port, r.rejected);
  endfunction

  always @(posedge clk) begin
    route_result_t got;
    route_result_t want;
    route_result_t fresh;
    if (rst_n) begin
      if (out_valid) begin
        got = {out_hit, out_matched_prefix, out_matched_len, out_out_port, out_add_rejected};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("unexpected route result: %s", show_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display("route result mismatch: expected %s, got %s",
                       show_result(want), show_result(got));
          end
        end
      end
      if (start && !busy) begin
        fresh = predict_route_result(lpm_pkg::mode_t'(in_mode), in_address,
                                     in_prefix_len, in_port);
        pending_results = {pending_results, fresh};
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input lpm_pkg::mode_t mode,
                           input logic [lpm_pkg::ADDR_W-1:0] addr,
                           input logic [lpm_pkg::LEN_W-1:0] plen,
                           input logic [lpm_pkg::PORT_W-1:0] prt);
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      if (quiet_left > 0)
        quiet_left--;
      else if ($urandom_range(0, 24) == 0)
        quiet_left = $urandom_range(10, 60);
      else if ($urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 10);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_address <= addr;
    in_prefix_len <= plen;
    in_port <= prt;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Favor routes nested under or tied with stored ones
  task automatic send_random_add();
    logic [lpm_pkg::ADDR_W-1:0] addr;
    logic [lpm_pkg::ADDR_W-1:0] keep;
    logic [lpm_pkg::LEN_W-1:0]  plen;
    int unsigned                idx;
    int unsigned                pick;
    pick = $urandom_range(0, 9);
    addr = $urandom();
    plen = 6'($urandom_range(1, 32));
    if (route_count > 0 && pick < 5) begin
      idx = $urandom_range(0, route_count - 1);
      keep = prefix_keep(route_len[idx]);
      addr = (route_prefix[idx] & keep) | (addr & ~keep);
      plen = (pick < 3) ? 6'($urandom_range(route_len[idx], 32)) : route_len[idx];
    end else if (pick == 9) begin
      plen = 6'($urandom_range(33, 63));
    end
    send_item(lpm_pkg::MODE_ADD, addr, plen, 8'($urandom_range(0, 255)));
  endtask

  // Mostly addresses under a stored route, some with one compared bit flipped
  task automatic send_random_lookup();
    logic [lpm_pkg::ADDR_W-1:0] addr;
    logic [lpm_pkg::ADDR_W-1:0] keep;
    int unsigned                idx;
    addr = $urandom();
    case ($urandom_range(0, 19))
      0: addr = '0;
      1: addr = '1;
      2, 3, 4, 5: ;
      default: begin
        if (route_count > 0) begin
          idx = $urandom_range(0, route_count - 1);
          keep = prefix_keep(route_len[idx]);
          addr = (route_prefix[idx] & keep) | (addr & ~keep);
          if (route_len[idx] != '0 && $urandom_range(0, 3) == 0)
            addr ^= 32'h8000_0000 >> $urandom_range(0, route_len[idx] - 1);
        end
      end
    endcase
    send_item(lpm_pkg::MODE_LOOKUP, addr, 6'($urandom_range(0, 63)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic test_empty_table_miss();
    send_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'd255);
  endtask

  task automatic test_directed_routes();
    send_item(lpm_pkg::MODE_ADD, 32'h0A00_0000, 6'd8, 8'd1);
    send_item(lpm_pkg::MODE_ADD, 32'h0A01_FFFF, 6'd16, 8'd2);
    send_item(lpm_pkg::MODE_ADD, 32'h0A01_0203, 6'd32, 8'd255);
    send_item(lpm_pkg::MODE_ADD, 32'h0AFF_FFFF, 6'd8, 8'd4);
    send_item(lpm_pkg::MODE_ADD, 32'hC0A8_0101, 6'd63, 8'd0);
    send_item(lpm_pkg::MODE_ADD, 32'hFFFF_FFFF, 6'd1, 8'd128);
    send_item(lpm_pkg::MODE_ADD, 32'h0000_0000, 6'd33, 8'd7);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0A01_FFFE, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0A01_0202, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0A7F_0000, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'hC0A8_0101, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'hC0A8_0100, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0);
  endtask

  // Fill to one short of full, leaving the last slot for the default route
  task automatic test_random_routes();
    for (int unsigned i = 0; i < 700; i++) begin
      if (route_count < DEPTH - 1 &&
          $urandom_range(0, 699 - i) < DEPTH - 1 - route_count)
        send_random_add();
      else
        send_random_lookup();
    end
  endtask

  task automatic test_default_route();
    send_item(lpm_pkg::MODE_ADD, 32'h89AB_CDEF, 6'd0, 8'd200);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0);
    send_item(lpm_pkg::MODE_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0);
    for (int unsigned i = 0; i < 300; i++)
      send_random_lookup();
  endtask

  task automatic test_full_table();
    send_item(lpm_pkg::MODE_ADD, 32'hFFFF_FFFF, 6'd63, 8'd255);
    send_item(lpm_pkg::MODE_ADD, 32'h0000_0000, 6'd0, 8'd0);
    for (int unsigned i = 0; i < 700; i++) begin
      if (i == 500)
        steady = 1'b1;
      if ($urandom_range(0, 3) == 0)
        send_item(lpm_pkg::MODE_ADD, $urandom(), 6'($urandom_range(0, 63)),
                  8'($urandom_range(0, 255)));
      else
        send_random_lookup();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = lpm_pkg::MODE_ADD;
    in_address = '0;
    in_prefix_len = '0;
    in_port = '0;
    route_count = 0;
    mismatches = 0;
    steady = 1'b0;
    quiet_left = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table_miss();
    test_directed_routes();
    test_random_routes();
    test_default_route();
    test_full_table();

    start <= 1'b0;
    for (int unsigned guard = 0;
         pending_results.size() != 0 && guard < DRAIN_CYCLES; guard++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lpm_pkg.sv
rtl/lpm_mem.sv
rtl/lpm_best.sv
rtl/longest_prefix_match_table.sv
tb/longest_prefix_match_table_test.sv
